>>> rtl/core/pcs_pkg.sv
// pcs_pkg: shared widths, register indexes, reset values and the queue item type
// for the pressure compensation and smoothing block; depends on nothing
`default_nettype none

package pcs_pkg;

    // register file
    localparam int NUM_REGS  = 6;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 64;
    localparam int GAIN_W    = 16;

    localparam logic [IDX_W-1:0] REG_PRESSURE_LINE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TEMP_NUM_LINE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_CORR     = 3'd2;
    localparam logic [IDX_W-1:0] REG_TEMP_DEN_LINE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FAST_GAIN      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SLOW_GAIN      = 3'd5;

    localparam logic [CFG_W-1:0]  PRESSURE_LINE_RST = 64'h0100_0000_0000_0000;
    localparam logic [GAIN_W-1:0] FAST_GAIN_RST     = 16'd3277;
    localparam logic [GAIN_W-1:0] SLOW_GAIN_RST     = 16'd16;

    // linear terms in Q.24
    localparam int A_W = 50;
    localparam int B_W = 42;
    localparam int C_W = 50;
    localparam int D_W = 42;

    // average state width, Q24.24
    localparam int AVG_W = 48;

    // default depth of the front to back queue
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic signed [C_W-1:0] c;
        logic signed [D_W-1:0] d;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/core/pcs_front.sv
// pcs_front: accepts samples and forms the four linear Q.24 terms
// depends on pcs_pkg
`default_nettype none

module pcs_front (
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [15:0]          s_raw_pressure,
    input  wire logic signed [8:0]    s_temperature,
    input  wire logic [63:0]          pressure_line,
    input  wire logic [63:0]          temp_num_line,
    input  wire logic [63:0]          press_corr_line,
    input  wire logic [63:0]          temp_den_line,
    input  wire logic                 q_full,
    output logic                      q_push,
    output pcs_pkg::item_t            q_item
);

    logic signed [16:0] p_s;
    logic signed [48:0] kp_p;
    logic signed [48:0] dkp_p;
    logic signed [40:0] kt_t;
    logic signed [40:0] dkt_t;

    // handshake: take a sample whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // slope products
    assign p_s   = {1'b0, s_raw_pressure};
    assign kp_p  = $signed(pressure_line[63:32]) * p_s;
    assign dkp_p = $signed(press_corr_line[63:32]) * p_s;
    assign kt_t  = $signed(temp_num_line[63:32]) * s_temperature;
    assign dkt_t = $signed(temp_den_line[63:32]) * s_temperature;

    // offsets plus slopes
    assign q_item.a = {{18{pressure_line[31]}}, pressure_line[31:0]} + {kp_p[48], kp_p};
    assign q_item.b = {{10{temp_num_line[31]}}, temp_num_line[31:0]} + {kt_t[40], kt_t};
    assign q_item.c = {{18{press_corr_line[31]}}, press_corr_line[31:0]}
                    + {dkp_p[48], dkp_p};
    assign q_item.d = {{10{temp_den_line[31]}}, temp_den_line[31:0]} + {dkt_t[40], dkt_t};

endmodule

`default_nettype wire

>>> rtl/core/pcs_queue.sv
// pcs_queue: small fifo of linear terms between front and back
// depends on pcs_pkg
`default_nettype none

module pcs_queue #(
    parameter int DEPTH = pcs_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire pcs_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output pcs_pkg::item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    pcs_pkg::item_t        mem [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pcs_back.sv
// pcs_back: serial multiply, serial divide, averaging and the output register
// depends on pcs_pkg
`default_nettype none

module pcs_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire pcs_pkg::item_t q_item,
    output logic                q_pop,
    input  wire logic [15:0]    fast_gain,
    input  wire logic [15:0]    slow_gain,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic signed [15:0]  m_smoothed_pressure,
    output logic signed [15:0]  m_pressure_change,
    output logic                m_range_flag
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_PREP = 4'd2;
    localparam logic [3:0] ST_DIVI = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_AP   = 4'd5;
    localparam logic [3:0] ST_SAT  = 4'd6;
    localparam logic [3:0] ST_EMA1 = 4'd7;
    localparam logic [3:0] ST_EMA2 = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    localparam logic [5:0] MUL_LAST = 6'd12;
    localparam logic [5:0] DIV_LAST = 6'd50;
    localparam logic signed [93:0] UNITY = 94'sh1 << 48;
    localparam logic [47:0] AVG_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] AVG_MIN = 48'h8000_0000_0000;

    // saturating cut toward zero of a Q.24 value to 16 bits, flag on top
    function automatic logic [16:0] trunc_sat(input logic [48:0] v);
        logic [48:0] m;
        logic [24:0] w;
        logic [16:0] r;
        m = v[48] ? (~v + 49'd1) : v;
        w = m[48:24];
        if (!v[48]) begin
            r = (w > 25'd32767) ? {1'b1, 16'h7FFF} : {1'b0, w[15:0]};
        end else if (w > 25'd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, 16'(~w[15:0] + 16'd1)};
        end
        return r;
    endfunction

    logic [3:0]           state_reg;
    logic [5:0]           cnt_reg;
    logic [41:0]          mb_reg;
    logic [41:0]          md_reg;
    logic [51:0]          mc_reg;
    logic                 sb_reg, sc_reg, sd_reg;
    logic signed [49:0]   a_reg;
    logic [91:0]          accn_reg;
    logic [91:0]          accd_reg;
    logic [92:0]          den_mag_reg;
    logic                 qneg_reg;
    logic                 qsat_reg;
    logic [92:0]          rem_reg;
    logic [50:0]          nlow_reg;
    logic [50:0]          quo_reg;
    logic signed [59:0]   ap100_reg;
    logic [47:0]          ap_reg;
    logic                 flag_reg;
    logic [64:0]          fprod_reg, sprod_reg;
    logic                 fneg_reg, sneg_reg;
    logic [47:0]          fast_avg_reg;
    logic [47:0]          slow_avg_reg;

    logic [3:0]           dig;
    logic [45:0]          pb, pd;
    logic [93:0]          dc_u;
    logic signed [93:0]   dc_s, den_s;
    logic [93:0]          rem_sh;
    logic [93:0]          den_ext;
    logic signed [51:0]   qs;
    logic signed [52:0]   apsum;
    logic [48:0]          fdelta, sdelta, fmag, smag;
    logic [48:0]          avg_diff;
    logic [16:0]          fout, dout;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // multiply digit products
    assign dig = mc_reg[51:48];
    assign pb  = mb_reg * dig;
    assign pd  = md_reg * dig;

    // denominator 1 - d*c in Q.48
    assign dc_u  = {2'b00, accd_reg};
    assign dc_s  = (sd_reg ^ sc_reg) ? -$signed(dc_u) : $signed(dc_u);
    assign den_s = UNITY - dc_s;

    // divider step
    assign rem_sh  = {rem_reg, nlow_reg[50]};
    assign den_ext = {1'b0, den_mag_reg};

    // signed quotient plus offset; the AP state scales the sum by 100
    assign qs    = qneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign apsum = {{3{a_reg[49]}}, a_reg} + {qs[51], qs};

    // average deltas
    assign fdelta = {ap_reg[47], ap_reg} - {fast_avg_reg[47], fast_avg_reg};
    assign sdelta = {ap_reg[47], ap_reg} - {slow_avg_reg[47], slow_avg_reg};
    assign fmag   = fdelta[48] ? (~fdelta + 49'd1) : fdelta;
    assign smag   = sdelta[48] ? (~sdelta + 49'd1) : sdelta;

    // output values
    assign avg_diff = {fast_avg_reg[47], fast_avg_reg} - {slow_avg_reg[47], slow_avg_reg};
    assign fout     = trunc_sat({fast_avg_reg[47], fast_avg_reg});
    assign dout     = trunc_sat(avg_diff);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid      <= 1'b0;
            fast_avg_reg <= '0;
            slow_avg_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            if (m_valid && m_ready && (state_reg != ST_OUT)) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        a_reg    <= q_item.a;
                        sb_reg   <= q_item.b[41];
                        sc_reg   <= q_item.c[49];
                        sd_reg   <= q_item.d[41];
                        mb_reg   <= q_item.b[41] ? 42'(-q_item.b) : q_item.b;
                        md_reg   <= q_item.d[41] ? 42'(-q_item.d) : q_item.d;
                        mc_reg   <= {2'b00, q_item.c[49] ? 50'(-q_item.c) : q_item.c};
                        accn_reg <= '0;
                        accd_reg <= '0;
                        flag_reg <= 1'b0;
                        cnt_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    accn_reg <= {accn_reg[87:0], 4'b0000} + {46'd0, pb};
                    accd_reg <= {accd_reg[87:0], 4'b0000} + {46'd0, pd};
                    mc_reg   <= {mc_reg[47:0], 4'b0000};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == MUL_LAST) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    den_mag_reg <= den_s[93] ? 93'(-den_s) : den_s[92:0];
                    qneg_reg    <= ((sb_reg ^ sc_reg) && (accn_reg != '0)) ^ den_s[93];
                    if (den_s == '0) begin
                        flag_reg  <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIVI;
                    end
                end
                ST_DIVI: begin
                    rem_reg  <= {28'd0, accn_reg[91:27]};
                    nlow_reg <= {accn_reg[26:0], 24'd0};
                    quo_reg  <= '0;
                    cnt_reg  <= '0;
                    if ({28'd0, accn_reg[91:27]} >= den_mag_reg) begin
                        qsat_reg  <= 1'b1;
                        state_reg <= ST_AP;
                    end else begin
                        qsat_reg  <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_sh >= den_ext) begin
                        rem_reg <= 93'(rem_sh - den_ext);
                        quo_reg <= {quo_reg[49:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[92:0];
                        quo_reg <= {quo_reg[49:0], 1'b0};
                    end
                    nlow_reg <= {nlow_reg[49:0], 1'b0};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_AP;
                    end
                end
                ST_AP: begin
                    ap100_reg <= apsum * $signed(8'd100);
                    state_reg <= ST_SAT;
                end
                ST_SAT: begin
                    if (qsat_reg) begin
                        flag_reg <= 1'b1;
                        ap_reg   <= qneg_reg ? AVG_MIN : AVG_MAX;
                    end else if (!ap100_reg[59] && (ap100_reg[58:47] != '0)) begin
                        flag_reg <= 1'b1;
                        ap_reg   <= AVG_MAX;
                    end else if (ap100_reg[59] && (ap100_reg[58:47] != '1)) begin
                        flag_reg <= 1'b1;
                        ap_reg   <= AVG_MIN;
                    end else begin
                        ap_reg   <= ap100_reg[47:0];
                    end
                    state_reg <= ST_EMA1;
                end
                ST_EMA1: begin
                    fprod_reg <= fmag * fast_gain;
                    sprod_reg <= smag * slow_gain;
                    fneg_reg  <= fdelta[48];
                    sneg_reg  <= sdelta[48];
                    state_reg <= ST_EMA2;
                end
                ST_EMA2: begin
                    fast_avg_reg <= fneg_reg ? 48'(fast_avg_reg - fprod_reg[64:16])
                                             : 48'(fast_avg_reg + fprod_reg[64:16]);
                    slow_avg_reg <= sneg_reg ? 48'(slow_avg_reg - sprod_reg[64:16])
                                             : 48'(slow_avg_reg + sprod_reg[64:16]);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid             <= 1'b1;
                        m_smoothed_pressure <= fout[15:0];
                        m_pressure_change   <= dout[15:0];
                        m_range_flag        <= flag_reg | fout[16] | dout[16];
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // remainder stays below the divisor throughout the division
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den_mag_reg))
        else $error("divider remainder not below divisor");

    // a popped item always starts the multiply
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_MUL))
        else $error("pop did not start multiply");

    // multiply count stays within its digit range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (cnt_reg <= MUL_LAST))
        else $error("multiply step count out of range");

    // averages only move in the update state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EMA2) |=> $stable(fast_avg_reg) && $stable(slow_avg_reg))
        else $error("average changed outside update");

endmodule

`default_nettype wire

>>> rtl/core/pressure_compensate_and_smooth_top.sv
// pressure_compensate_and_smooth_top: register file and the front, queue and back parts
// depends on pcs_pkg, pcs_front, pcs_queue, pcs_back
//
// Usage: one sample (raw pressure count, signed temperature) enters on the s_
// valid/ready channel; one result (fast average, fast minus slow average, range
// flag) leaves on the m_ valid/ready channel for each sample, in order.
// The front forms the linear Q.24 terms in the transfer cycle and writes them to a
// small queue, so samples are taken while the back is busy.
// The back handles one sample at a time: setup, a serial multiplier with 4-bit
// digits, a restoring divider that forms one quotient bit per cycle, then scaling,
// averaging and output; it takes no new sample before its result is registered.
// A zero denominator skips the divide and averaging.
// Coefficients are written over cfg_wen/cfg_index/cfg_wdata; the user must write
// them only while the block is idle, which the block itself does not enforce;
// indexes past the last register are ignored.
// Reset (aresetn low, synchronous) restores the default coefficients and gains,
// clears both averages and empties the queue and the output register.
// When the receiver stalls, the result is held in the output register, the back
// waits with the next result, and the queue fills before s_ready drops.
`default_nettype none

module pressure_compensate_and_smooth_top #(
    parameter int QUEUE_DEPTH = pcs_pkg::QUEUE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [15:0]                  s_raw_pressure,
    input  wire logic signed [8:0]            s_temperature,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [15:0]                m_smoothed_pressure,
    output logic signed [15:0]                m_pressure_change,
    output logic                              m_range_flag,
    input  wire logic                         cfg_wen,
    input  wire logic [pcs_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [pcs_pkg::CFG_W-1:0]    cfg_wdata
);

    logic [63:0]      pressure_line_reg;
    logic [63:0]      temp_num_line_reg;
    logic [63:0]      press_corr_line_reg;
    logic [63:0]      temp_den_line_reg;
    logic [15:0]      fast_gain_reg;
    logic [15:0]      slow_gain_reg;

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_not_empty;
    pcs_pkg::item_t   push_item;
    pcs_pkg::item_t   pop_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressure_line_reg   <= pcs_pkg::PRESSURE_LINE_RST;
            temp_num_line_reg   <= '0;
            press_corr_line_reg <= '0;
            temp_den_line_reg   <= '0;
            fast_gain_reg       <= pcs_pkg::FAST_GAIN_RST;
            slow_gain_reg       <= pcs_pkg::SLOW_GAIN_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                pcs_pkg::REG_PRESSURE_LINE: pressure_line_reg   <= cfg_wdata;
                pcs_pkg::REG_TEMP_NUM_LINE: temp_num_line_reg   <= cfg_wdata;
                pcs_pkg::REG_PRESS_CORR:    press_corr_line_reg <= cfg_wdata;
                pcs_pkg::REG_TEMP_DEN_LINE: temp_den_line_reg   <= cfg_wdata;
                pcs_pkg::REG_FAST_GAIN:     fast_gain_reg       <= cfg_wdata[15:0];
                pcs_pkg::REG_SLOW_GAIN:     slow_gain_reg       <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // front: sample transfer and linear terms
    pcs_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_pressure  (s_raw_pressure),
        .s_temperature   (s_temperature),
        .pressure_line   (pressure_line_reg),
        .temp_num_line   (temp_num_line_reg),
        .press_corr_line (press_corr_line_reg),
        .temp_den_line   (temp_den_line_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    // queue between front and back
    pcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    // back: compensation, averaging and result register
    pcs_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (q_not_empty),
        .q_item              (pop_item),
        .q_pop               (q_pop),
        .fast_gain           (fast_gain_reg),
        .slow_gain           (slow_gain_reg),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_smoothed_pressure (m_smoothed_pressure),
        .m_pressure_change   (m_pressure_change),
        .m_range_flag        (m_range_flag)
    );

endmodule

`default_nettype wire

>>> test/tb_top.sv
// tb_top: self-checking testbench for pressure_compensate_and_smooth_top
// depends on pcs_pkg and the top level; carries its own bit-exact predictor
`timescale 1ns / 1ps

module tb_top;

    localparam longint AVG_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint AVG_LO = -AVG_HI - 1;

    typedef struct {
        logic signed [15:0] smoothed;
        logic signed [15:0] change;
        logic               flag;
    } reading_t;

    // directed table rows: a sample, or a coefficient setup before the next sample
    typedef enum int {
        ROW_SAMPLE, ROW_ZERO_DEN, ROW_DEFAULTS, ROW_ALL_ONES, ROW_GAIN_MAX
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [15:0]        raw;
        logic signed [8:0]  temp;
        bit                 typed;
        reading_t           want;
    } row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [15:0]                   s_raw_pressure = '0;
    logic signed [8:0]             s_temperature = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [15:0]            m_smoothed_pressure;
    logic signed [15:0]            m_pressure_change;
    logic                          m_range_flag;
    logic                          cfg_wen = 1'b0;
    logic [pcs_pkg::IDX_W-1:0]     cfg_index = '0;
    logic [pcs_pkg::CFG_W-1:0]     cfg_wdata = '0;

    // predictor copy of registers and averages
    logic [63:0]  coef [pcs_pkg::NUM_REGS];
    longint       fast_avg, slow_avg;
    reading_t     pending [$];
    int           errors = 0;
    int           samples_sent = 0;
    int           readings_seen = 0;
    int           flagged_seen = 0;
    bit           no_idle = 1'b0;
    int           stall_left = 0;

    pressure_compensate_and_smooth_top dut (.*);

    always #5 aclk = ~aclk;

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint frac_cut(longint v);
        return (v < 0) ? -((-v) >>> 24) : (v >>> 24);
    endfunction

    function automatic logic signed [15:0] clamp16(longint v, ref logic flag);
        if (v > 32767) begin
            flag = 1'b1;
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            flag = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic longint ema_step(longint avg, longint target, logic [15:0] g);
        longint      delta;
        logic [63:0] mag, stp;
        delta = target - avg;
        mag = (delta < 0) ? -delta : delta;
        stp = (mag * {48'd0, g}) >> 16;
        return (delta < 0) ? avg - longint'(stp) : avg + longint'(stp);
    endfunction

    // compensated pressure, both averages and the saturated outputs
    function automatic reading_t compensate(logic [15:0] raw, logic signed [8:0] tc);
        longint                p, t, a, b, c, d, apv;
        logic signed [127:0]   aw, bw, cw, dw, num, den, q, ap;
        logic [127:0]          mn, md, qu;
        logic                  flag;
        reading_t              r;
        p = longint'({48'd0, raw});
        t = tc;
        a = longint'(signed'(coef[pcs_pkg::REG_PRESSURE_LINE][31:0]))
            + longint'(signed'(coef[pcs_pkg::REG_PRESSURE_LINE][63:32])) * p;
        b = longint'(signed'(coef[pcs_pkg::REG_TEMP_NUM_LINE][31:0]))
            + longint'(signed'(coef[pcs_pkg::REG_TEMP_NUM_LINE][63:32])) * t;
        c = longint'(signed'(coef[pcs_pkg::REG_PRESS_CORR][31:0]))
            + longint'(signed'(coef[pcs_pkg::REG_PRESS_CORR][63:32])) * p;
        d = longint'(signed'(coef[pcs_pkg::REG_TEMP_DEN_LINE][31:0]))
            + longint'(signed'(coef[pcs_pkg::REG_TEMP_DEN_LINE][63:32])) * t;
        aw = a;
        bw = b;
        cw = c;
        dw = d;
        num = bw * cw;
        den = 128'sh1_0000_0000_0000 - dw * cw;
        flag = 1'b0;
        if (den == 0) begin
            flag = 1'b1;
        end else begin
            mn = (num < 0) ? -num : num;
            md = (den < 0) ? -den : den;
            qu = (mn << 24) / md;
            q = qu;
            if ((num < 0) != (den < 0)) q = -q;
            ap = (aw + q) * 128'sd100;
            if (ap > 128'(AVG_HI)) begin
                flag = 1'b1;
                apv = AVG_HI;
            end else if (ap < 128'(AVG_LO)) begin
                flag = 1'b1;
                apv = AVG_LO;
            end else begin
                apv = ap[63:0];
            end
            fast_avg = ema_step(fast_avg, apv, coef[pcs_pkg::REG_FAST_GAIN][15:0]);
            slow_avg = ema_step(slow_avg, apv, coef[pcs_pkg::REG_SLOW_GAIN][15:0]);
        end
        r.smoothed = clamp16(frac_cut(fast_avg), flag);
        r.change = clamp16(frac_cut(fast_avg - slow_avg), flag);
        r.flag = flag;
        return r;
    endfunction

    // result side: random stalls, check each transfer against the oldest prediction
    always @(posedge aclk) begin
        reading_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            readings_seen++;
            if (m_range_flag) flagged_seen++;
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                w = pending.pop_front();
                if (m_smoothed_pressure !== w.smoothed) begin
                    $error("smoothed_pressure expected %0d actual %0d",
                           w.smoothed, m_smoothed_pressure);
                    errors++;
                end
                if (m_pressure_change !== w.change) begin
                    $error("pressure_change expected %0d actual %0d",
                           w.change, m_pressure_change);
                    errors++;
                end
                if (m_range_flag !== w.flag) begin
                    $error("range_flag expected %0d actual %0d", w.flag, m_range_flag);
                    errors++;
                end
            end
            stall_left <= no_idle ? 0 : $urandom_range(0, 14);
            if (!no_idle && $urandom_range(0, 1)) m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (stall_left == 0) m_ready <= 1'b1;
            else stall_left <= stall_left - 1;
        end
    end

    task automatic put_reg(logic [pcs_pkg::IDX_W-1:0] idx, logic [63:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx < pcs_pkg::NUM_REGS)
            coef[idx] = (idx >= pcs_pkg::REG_FAST_GAIN) ? {48'd0, val[15:0]} : val;
    endtask

    task automatic close_writes();
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_sample(logic [15:0] raw, logic signed [8:0] tc);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_pressure <= raw;
        s_temperature <= tc;
        do @(posedge aclk); while (!s_ready);
        pending.push_back(compensate(raw, tc));
        samples_sent++;
    endtask

    // typed rows: expectation already queued, predictor already stepped
    task automatic send_typed(logic [15:0] raw, logic signed [8:0] tc);
        s_valid <= 1'b1;
        s_raw_pressure <= raw;
        s_temperature <= tc;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    function automatic logic [31:0] rand_q(int unsigned mag);
        int signed v;
        v = $urandom_range(0, mag);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic write_defaults();
        put_reg(pcs_pkg::REG_PRESSURE_LINE, pcs_pkg::PRESSURE_LINE_RST);
        put_reg(pcs_pkg::REG_TEMP_NUM_LINE, 64'd0);
        put_reg(pcs_pkg::REG_PRESS_CORR, 64'd0);
        put_reg(pcs_pkg::REG_TEMP_DEN_LINE, 64'd0);
        put_reg(pcs_pkg::REG_FAST_GAIN, {48'd0, pcs_pkg::FAST_GAIN_RST});
        put_reg(pcs_pkg::REG_SLOW_GAIN, {48'd0, pcs_pkg::SLOW_GAIN_RST});
        close_writes();
    endtask

    // coefficient sets: 0 moderate, 1 any bits, 2 gains at extremes
    task automatic write_random_set(int style);
        logic [63:0] v [pcs_pkg::NUM_REGS];
        if (style == 1) begin
            foreach (v[i]) v[i] = {$urandom, $urandom};
        end else begin
            v[0] = {rand_q(90000), rand_q(32'h7FFF_FFFF)};
            v[1] = {rand_q(1 << 18), rand_q(1 << 25)};
            v[2] = {rand_q(1 << 10), rand_q(1 << 22)};
            v[3] = {rand_q(1 << 12), rand_q(1 << 20)};
            v[4] = {$urandom, $urandom};
            v[5] = {$urandom, 16'd0, 16'($urandom_range(0, 800))};
            if (style == 2) begin
                v[4][15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                v[5][15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
        end
        foreach (v[i]) put_reg(pcs_pkg::IDX_W'(i), v[i]);
        // indexes past the register file must be ignored
        put_reg(pcs_pkg::IDX_W'(pcs_pkg::NUM_REGS), {$urandom, $urandom});
        put_reg(pcs_pkg::IDX_W'(pcs_pkg::NUM_REGS + 1), {$urandom, $urandom});
        close_writes();
    endtask

    row_t plan [] = '{
        '{ROW_SAMPLE,   16'd0,     9'sd0,    1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_ZERO_DEN, 16'd0,     9'sd0,    1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'd123,   -9'sd5,   1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{ROW_SAMPLE,   16'hFFFF,  9'sd255,  1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{ROW_DEFAULTS, 16'd0,     9'sd0,    1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'd100,   9'sd20,   1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'hFFFF,  9'sd255,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'hFFFF,  -9'sd256, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'd0,     -9'sd256, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'd1,     9'sd1,    1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_GAIN_MAX, 16'd0,     9'sd0,    1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'd200,   9'sd0,    1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'hFFFF,  9'sd100,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'd0,     9'sd0,    1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_ALL_ONES, 16'd0,     9'sd0,    1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'hFFFF,  9'sd255,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'h8000,  -9'sd256, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{ROW_SAMPLE,   16'd0,     -9'sd1,   1'b0, '{16'sd0, 16'sd0, 1'b0}}
    };

    initial begin
        int n;
        coef[pcs_pkg::REG_PRESSURE_LINE] = pcs_pkg::PRESSURE_LINE_RST;
        coef[pcs_pkg::REG_TEMP_NUM_LINE] = '0;
        coef[pcs_pkg::REG_PRESS_CORR] = '0;
        coef[pcs_pkg::REG_TEMP_DEN_LINE] = '0;
        coef[pcs_pkg::REG_FAST_GAIN] = {48'd0, pcs_pkg::FAST_GAIN_RST};
        coef[pcs_pkg::REG_SLOW_GAIN] = {48'd0, pcs_pkg::SLOW_GAIN_RST};
        fast_avg = 0;
        slow_avg = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_SAMPLE: begin
                    if (plan[i].typed) begin
                        void'(compensate(plan[i].raw, plan[i].temp));
                        drain();
                        pending.push_back(plan[i].want);
                        // typed rows still advance the predictor state above
                        send_typed(plan[i].raw, plan[i].temp);
                    end else begin
                        send_sample(plan[i].raw, plan[i].temp);
                    end
                end
                ROW_ZERO_DEN: begin
                    // dT0 = dP0 = 1.0 makes the denominator exactly zero
                    drain();
                    put_reg(pcs_pkg::REG_PRESS_CORR, 64'h0000_0000_0100_0000);
                    put_reg(pcs_pkg::REG_TEMP_DEN_LINE, 64'h0000_0000_0100_0000);
                    close_writes();
                end
                ROW_DEFAULTS: begin
                    drain();
                    write_defaults();
                end
                ROW_GAIN_MAX: begin
                    drain();
                    put_reg(pcs_pkg::REG_FAST_GAIN, 64'hFFFF_FFFF_FFFF_FFFF);
                    put_reg(pcs_pkg::REG_SLOW_GAIN, 64'd0);
                    close_writes();
                end
                default: begin
                    drain();
                    for (int r = 0; r < pcs_pkg::NUM_REGS; r++)
                        put_reg(pcs_pkg::IDX_W'(r), '1);
                    close_writes();
                end
            endcase
        end

        // random phases, each with its own coefficients and idling mode
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            no_idle = (ph % 4 == 3);
            write_random_set(ph == 5 ? 1 : (ph % 3 == 2 ? 2 : 0));
            n = 75;
            for (int k = 0; k < n; k++) begin
                send_sample(16'($urandom), 9'($urandom));
            end
        end
        drain();
        no_idle = 1'b0;
        repeat (80) @(posedge aclk);
        if (pending.size() != 0) begin
            $error("%0d results never arrived", pending.size());
            errors++;
        end
        $display("covered %0d samples, %0d results (%0d flagged) over 12 coefficient sets",
                 samples_sent, readings_seen, flagged_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
